[src/fsbc_pkg.sv]
`default_nettype none

package fsbc_pkg;

	localparam int PLANE_REGS      = 6;
	localparam int PLANE_COUNT_DEF = 6;

	localparam int CFG_IDX_W = 3;
	localparam int PLANE_W   = 64;
	localparam int COEF_W    = 12;
	localparam int D_W       = 28;
	localparam int COORD_W   = 24;
	localparam int RAD_W     = 23;
	localparam int AXIS_W    = 60;
	localparam int COMP_W    = 20;
	localparam int CONT_W    = 2;

	// Scale of d and radius to the Q.18 grid of the products
	localparam int FRAC_SHIFT = 10;

	typedef enum logic [CONT_W-1:0] {
		CONT_OUTSIDE    = 2'd0,
		CONT_INTERSECTS = 2'd1,
		CONT_INSIDE     = 2'd2
	} cont_t;

	localparam logic OP_SPHERE = 1'b0;
	localparam logic OP_BOX    = 1'b1;

	typedef struct packed {
		logic                       operation;
		logic signed [COORD_W-1:0]  center_x;
		logic signed [COORD_W-1:0]  center_y;
		logic signed [COORD_W-1:0]  center_z;
		logic        [RAD_W-1:0]    sphere_radius;
		logic        [AXIS_W-1:0]   box_axis_u;
		logic        [AXIS_W-1:0]   box_axis_v;
		logic        [AXIS_W-1:0]   box_axis_w;
	} item_t;

	typedef struct packed {
		logic outside;
		logic intersects;
	} flags_t;

	typedef struct packed {
		item_t  item;
		flags_t flags;
	} stage_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [PLANE_W-1:0]   data;
	} cfg_wr_t;

endpackage

`default_nettype wire

[src/fsbc_vol_if.sv]
`default_nettype none

interface fsbc_vol_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        operation;
	logic signed [fsbc_pkg::COORD_W-1:0]         center_x;
	logic signed [fsbc_pkg::COORD_W-1:0]         center_y;
	logic signed [fsbc_pkg::COORD_W-1:0]         center_z;
	logic        [fsbc_pkg::RAD_W-1:0]           sphere_radius;
	logic        [fsbc_pkg::AXIS_W-1:0]          box_axis_u;
	logic        [fsbc_pkg::AXIS_W-1:0]          box_axis_v;
	logic        [fsbc_pkg::AXIS_W-1:0]          box_axis_w;

	modport source (output valid, operation, center_x, center_y, center_z, sphere_radius,
		box_axis_u, box_axis_v, box_axis_w, input ready);
	modport sink (input valid, operation, center_x, center_y, center_z, sphere_radius,
		box_axis_u, box_axis_v, box_axis_w, output ready);
endinterface

`default_nettype wire

[src/fsbc_res_if.sv]
`default_nettype none

interface fsbc_res_if;
	logic                             valid;
	logic                             ready;
	logic [fsbc_pkg::CONT_W-1:0]      containment;

	modport source (output valid, containment, input ready);
	modport sink (input valid, containment, output ready);
endinterface

`default_nettype wire

[src/fsbc_cfg_if.sv]
`default_nettype none

interface fsbc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [fsbc_pkg::CFG_IDX_W-1:0]     index;
	logic [fsbc_pkg::PLANE_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/frustum_sphere_box_cull.sv]
// Channel  | Dir | Handshake     | Word
// ---------+-----+---------------+---------------------------------------------
// volume   | in  | valid/ready   | operation, center xyz, radius, three axes
// result   | out | valid/ready   | containment (outside, intersects, inside)
// cfg      | in  | valid/ready   | plane register index and 64-bit plane
//
// One word is taken per cycle while the result is not stalled; a word passes the row
// of min(PLANE_COUNT, 6) plane cells, three stages each, before it comes out.
// arst_n clears all planes to zero and empties the row.
// A stalled result holds only the cells that are full; words keep entering
// until the row fills up. cfg is always ready.
`default_nettype none

module frustum_sphere_box_cull #(
	parameter int PLANE_COUNT = fsbc_pkg::PLANE_COUNT_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fsbc_vol_if.sink  volume,
	fsbc_res_if.source result,
	fsbc_cfg_if.sink  cfg
);
	import fsbc_pkg::*;

	// only six plane registers exist, so never test more than six planes
	localparam int TESTED = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;

	cfg_wr_t cfg_wr;

	logic   link_valid [TESTED+1];
	logic   link_ready [TESTED+1];
	stage_t link_stage [TESTED+1];

	cont_t  cont;

	// config writes are taken at once; indexes past the planes match no cell
	assign cfg.ready    = 1'b1;
	assign cfg_wr.valid = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	// enter the row with no plane failed yet
	assign link_valid[0]                    = volume.valid;
	assign volume.ready                     = link_ready[0];
	assign link_stage[0].item.operation     = volume.operation;
	assign link_stage[0].item.center_x      = volume.center_x;
	assign link_stage[0].item.center_y      = volume.center_y;
	assign link_stage[0].item.center_z      = volume.center_z;
	assign link_stage[0].item.sphere_radius = volume.sphere_radius;
	assign link_stage[0].item.box_axis_u    = volume.box_axis_u;
	assign link_stage[0].item.box_axis_v    = volume.box_axis_v;
	assign link_stage[0].item.box_axis_w    = volume.box_axis_w;
	assign link_stage[0].flags.outside      = 1'b0;
	assign link_stage[0].flags.intersects   = 1'b0;

	// one cell per tested plane, each owning its plane register
	for (genvar g = 0; g < TESTED; g++) begin : g_cell
		fsbc_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg_wr    (cfg_wr),
			.prv_valid (link_valid[g]),
			.prv_ready (link_ready[g]),
			.prv_stage (link_stage[g]),
			.nxt_valid (link_valid[g+1]),
			.nxt_ready (link_ready[g+1]),
			.nxt_stage (link_stage[g+1])
		);
	end

	// last cell's third stage is the output register; decode its flags
	always_comb begin
		if (link_stage[TESTED].flags.outside) begin
			cont = CONT_OUTSIDE;
		end else if (link_stage[TESTED].flags.intersects) begin
			cont = CONT_INTERSECTS;
		end else begin
			cont = CONT_INSIDE;
		end
	end

	assign result.valid       = link_valid[TESTED];
	assign link_ready[TESTED] = result.ready;
	assign result.containment = cont;

endmodule

`default_nettype wire

[src/fsbc_cell.sv]
`default_nettype none

module fsbc_cell #(
	parameter int CELL_IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fsbc_pkg::cfg_wr_t cfg_wr,
	input  wire logic              prv_valid,
	output logic                   prv_ready,
	input  wire fsbc_pkg::stage_t  prv_stage,
	output logic                   nxt_valid,
	input  wire logic              nxt_ready,
	output fsbc_pkg::stage_t       nxt_stage
);
	import fsbc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] MY_IDX = CFG_IDX_W'(CELL_IDX);

	localparam int PC_W   = COEF_W + COORD_W;   // coefficient times centre
	localparam int PA_W   = COEF_W + COMP_W;    // coefficient times axis component
	localparam int DIST_W = PC_W + 3;           // three products plus scaled d
	localparam int AX_W   = PA_W + 2;           // three axis products
	localparam int SUM_W  = DIST_W + 3;         // distance plus three projections
	localparam int RS_W   = RAD_W + FRAC_SHIFT; // scaled radius

	logic [PLANE_W-1:0] plane_q;

	logic signed [COEF_W-1:0] a_c, b_c, c_c;
	logic signed [D_W-1:0]    d_c;

	// stage 1: products
	logic                    v_s1;
	stage_t                  st_s1;
	logic signed [PC_W-1:0]  pcx_s1, pcy_s1, pcz_s1;
	logic signed [PA_W-1:0]  pu_s1 [3];
	logic signed [PA_W-1:0]  pv_s1 [3];
	logic signed [PA_W-1:0]  pw_s1 [3];

	// stage 2: dot sums
	logic                     v_s2;
	stage_t                   st_s2;
	logic signed [DIST_W-1:0] dist_s2;
	logic signed [AX_W-1:0]   du_s2, dv_s2, dw_s2;

	// stage 3: tested flags
	logic   v_s3;
	stage_t st_s3;

	logic en1, en2, en3;

	logic signed [COMP_W-1:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
	logic signed [D_W+FRAC_SHIFT-1:0] d_scaled;
	logic signed [DIST_W-1:0] dist_c;

	logic [AX_W-1:0]          au_c, av_c, aw_c;
	logic [DIST_W-1:0]        adist_c;
	logic [RS_W-1:0]          r_c;
	logic signed [SUM_W-1:0]  box_sum_c, sph_sum_c;
	logic                     box_out_c, sph_out_c, sph_isect_c;
	flags_t                   flags_c;

	assign a_c = plane_q[COEF_W-1:0];
	assign b_c = plane_q[2*COEF_W-1:COEF_W];
	assign c_c = plane_q[3*COEF_W-1:2*COEF_W];
	assign d_c = plane_q[PLANE_W-1:3*COEF_W];

	// hold this cell's plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_wr.valid && cfg_wr.index == MY_IDX) begin
			plane_q <= cfg_wr.data;
		end
	end

	// advance a stage when it is empty or the next one moves
	assign en3       = !v_s3 || nxt_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign prv_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= prv_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign ux = prv_stage.item.box_axis_u[COMP_W-1:0];
	assign uy = prv_stage.item.box_axis_u[2*COMP_W-1:COMP_W];
	assign uz = prv_stage.item.box_axis_u[3*COMP_W-1:2*COMP_W];
	assign vx = prv_stage.item.box_axis_v[COMP_W-1:0];
	assign vy = prv_stage.item.box_axis_v[2*COMP_W-1:COMP_W];
	assign vz = prv_stage.item.box_axis_v[3*COMP_W-1:2*COMP_W];
	assign wx = prv_stage.item.box_axis_w[COMP_W-1:0];
	assign wy = prv_stage.item.box_axis_w[2*COMP_W-1:COMP_W];
	assign wz = prv_stage.item.box_axis_w[3*COMP_W-1:2*COMP_W];

	always_ff @(posedge clk) begin
		if (en1) begin
			st_s1    <= prv_stage;
			pcx_s1   <= a_c * prv_stage.item.center_x;
			pcy_s1   <= b_c * prv_stage.item.center_y;
			pcz_s1   <= c_c * prv_stage.item.center_z;
			pu_s1[0] <= a_c * ux;
			pu_s1[1] <= b_c * uy;
			pu_s1[2] <= c_c * uz;
			pv_s1[0] <= a_c * vx;
			pv_s1[1] <= b_c * vy;
			pv_s1[2] <= c_c * vz;
			pw_s1[0] <= a_c * wx;
			pw_s1[1] <= b_c * wy;
			pw_s1[2] <= c_c * wz;
		end
	end

	assign d_scaled = {d_c, {FRAC_SHIFT{1'b0}}};
	assign dist_c   = DIST_W'(pcx_s1) + DIST_W'(pcy_s1) + DIST_W'(pcz_s1) + DIST_W'(d_scaled);

	always_ff @(posedge clk) begin
		if (en2) begin
			st_s2   <= st_s1;
			dist_s2 <= dist_c;
			du_s2   <= AX_W'(pu_s1[0]) + AX_W'(pu_s1[1]) + AX_W'(pu_s1[2]);
			dv_s2   <= AX_W'(pv_s1[0]) + AX_W'(pv_s1[1]) + AX_W'(pv_s1[2]);
			dw_s2   <= AX_W'(pw_s1[0]) + AX_W'(pw_s1[1]) + AX_W'(pw_s1[2]);
		end
	end

	always_comb begin
		au_c    = du_s2[AX_W-1] ? AX_W'(-du_s2) : AX_W'(du_s2);
		av_c    = dv_s2[AX_W-1] ? AX_W'(-dv_s2) : AX_W'(dv_s2);
		aw_c    = dw_s2[AX_W-1] ? AX_W'(-dw_s2) : AX_W'(dw_s2);
		adist_c = dist_s2[DIST_W-1] ? DIST_W'(-dist_s2) : DIST_W'(dist_s2);
		r_c     = {st_s2.item.sphere_radius, {FRAC_SHIFT{1'b0}}};

		box_sum_c = SUM_W'(dist_s2)
			+ $signed({{(SUM_W-AX_W){1'b0}}, au_c})
			+ $signed({{(SUM_W-AX_W){1'b0}}, av_c})
			+ $signed({{(SUM_W-AX_W){1'b0}}, aw_c});
		sph_sum_c = SUM_W'(dist_s2) + $signed({{(SUM_W-RS_W){1'b0}}, r_c});

		box_out_c   = box_sum_c[SUM_W-1];
		sph_out_c   = sph_sum_c[SUM_W-1];
		sph_isect_c = adist_c < DIST_W'(r_c);

		flags_c = st_s2.flags;
		if (st_s2.item.operation == OP_BOX) begin
			flags_c.outside = st_s2.flags.outside | box_out_c;
		end else begin
			flags_c.outside    = st_s2.flags.outside | sph_out_c;
			flags_c.intersects = st_s2.flags.intersects | sph_isect_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			st_s3 <= '{item: st_s2.item, flags: flags_c};
		end
	end

	assign nxt_valid = v_s3;
	assign nxt_stage = st_s3;

endmodule

`default_nettype wire
